FILE: sv/ibs_pkg.sv
package ibs_pkg;

    localparam int BUF_DEPTH_DEF = 64;
    localparam int POS_W         = 7;
    localparam int QDEPTH        = 4;
    localparam int QCNT_W        = $clog2(QDEPTH + 1);
    localparam int QPTR_W        = $clog2(QDEPTH);

    // item modes
    localparam logic [2:0] MODE_LOAD     = 3'd0;
    localparam logic [2:0] MODE_START_WR = 3'd1;
    localparam logic [2:0] MODE_START_RD = 3'd2;
    localparam logic [2:0] MODE_EVENT    = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;

    // bus status codes
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RSTART       = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;
    localparam logic [7:0] READ_BIT        = 8'h01;
    localparam logic [7:0] RDONE_CODE      = 8'h02;

    // bus actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_CONT  = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    // notices
    localparam logic [2:0] NT_NONE  = 3'd0;
    localparam logic [2:0] NT_WDONE = 3'd1;
    localparam logic [2:0] NT_RDONE = 3'd2;
    localparam logic [2:0] NT_WERR  = 3'd3;
    localparam logic [2:0] NT_RERR  = 3'd4;

    // phase as reported on the result
    localparam logic [1:0] PH_OUT_IDLE = 2'd0;
    localparam logic [1:0] PH_OUT_TX   = 2'd1;
    localparam logic [1:0] PH_OUT_RX   = 2'd2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_TX   = 3'b010,
        PH_RX   = 3'b100
    } phase_t;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [POS_W-1:0] rd_addr;
    } mem_req_t;

    // decoded result, before the store read data is merged in
    typedef struct packed {
        logic [1:0] bus_action;
        logic       ack_enable;
        logic [7:0] drive_byte;
        logic       drive_valid;
        logic       drive_from_mem;
        logic [2:0] notice;
        logic [7:0] notice_code;
        logic       refused;
        logic       read_from_mem;
        logic [1:0] phase_now;
    } stage_t;

    typedef struct packed {
        logic [1:0] bus_action;
        logic       ack_enable;
        logic [7:0] drive_byte;
        logic       drive_valid;
        logic [2:0] notice;
        logic [7:0] notice_code;
        logic       refused;
        logic [7:0] read_value;
        logic [1:0] phase_now;
    } result_t;

endpackage

FILE: sv/ibs_store.sv
module ibs_store #(
    parameter int BUF_DEPTH = ibs_pkg::BUF_DEPTH_DEF
) (
    input  logic             clk,
    input  ibs_pkg::mem_req_t req,
    output logic [7:0]       rd_data
);
    import ibs_pkg::*;

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0]  mem [BUF_DEPTH];
    logic [7:0]  rd_q_reg;
    logic        rd_ok_reg;
    logic [31:0] wa32;
    logic [31:0] ra32;
    logic        wr_ok;
    logic        rd_ok;

    assign wa32  = 32'(req.wr_addr);
    assign ra32  = 32'(req.rd_addr);
    assign wr_ok = req.wr_en && (wa32 < 32'(BUF_DEPTH));
    assign rd_ok = ra32 < 32'(BUF_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wa32[ADDR_W-1:0]] <= req.wr_data;
        end
        rd_q_reg  <= mem[ra32[ADDR_W-1:0]];
        rd_ok_reg <= rd_ok;
    end

    // out-of-range reads return zero
    assign rd_data = rd_ok_reg ? rd_q_reg : 8'h00;

endmodule

FILE: sv/ibs_front.sv
module ibs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        mode,
    input  logic [7:0]        dev_addr,
    input  logic [6:0]        xfer_len,
    input  logic [7:0]        bus_status,
    input  logic [7:0]        rx_byte,
    input  logic [5:0]        buf_index,
    input  logic [7:0]        buf_value,
    output ibs_pkg::stage_t   rec,
    output ibs_pkg::mem_req_t mem_req
);
    import ibs_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [7:0]       target_reg, target_next;
    logic [6:0]       remain_reg, remain_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] pos_inc;
    logic [6:0]       remain_dec;
    logic [2:0]       err_notice;
    stage_t           r;
    mem_req_t         m;

    assign pos_inc    = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    assign remain_dec = (remain_reg != 7'd0) ? remain_reg - 7'd1 : remain_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_TX:   err_notice = NT_WERR;
            PH_RX:   err_notice = NT_RERR;
            default: err_notice = NT_NONE;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        r           = '0;
        m           = '0;
        m.rd_addr   = pos_reg;

        unique case (mode) inside
            MODE_LOAD:
            begin
                m.wr_en   = 1'b1;
                m.wr_addr = POS_W'(buf_index);
                m.wr_data = buf_value;
            end
            MODE_START_WR, MODE_START_RD:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    r.refused = 1'b1;
                end
                else
                begin
                    target_next  = dev_addr;
                    remain_next  = xfer_len;
                    pos_next     = '0;
                    phase_next   = (mode == MODE_START_WR) ? PH_TX : PH_RX;
                    r.bus_action = ACT_START;
                end
            end
            MODE_EVENT:
            begin
                case (bus_status) inside
                    ST_START, ST_RSTART:
                    begin
                        r.drive_byte  = target_reg | ((phase_reg == PH_TX) ? 8'h00 : READ_BIT);
                        r.drive_valid = 1'b1;
                        r.bus_action  = ACT_CONT;
                    end
                    ST_SLAW_ACK, ST_DATA_TX_ACK:
                    begin
                        if (remain_reg != 7'd0)
                        begin
                            // next transmit byte comes from the store
                            r.drive_valid    = 1'b1;
                            r.drive_from_mem = 1'b1;
                            r.bus_action     = ACT_CONT;
                            pos_next         = pos_inc;
                            remain_next      = remain_dec;
                        end
                        else if (bus_status == ST_SLAW_ACK)
                        begin
                            r.notice      = err_notice;
                            r.notice_code = (err_notice != NT_NONE) ? bus_status : 8'h00;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            r.notice      = NT_WDONE;
                            r.notice_code = bus_status;
                            r.bus_action  = ACT_STOP;
                            phase_next    = PH_IDLE;
                        end
                    end
                    ST_SLAR_ACK:
                    begin
                        r.bus_action = ACT_CONT;
                        r.ack_enable = (remain_reg != 7'd1);
                    end
                    ST_DATA_RX_ACK:
                    begin
                        m.wr_en      = 1'b1;
                        m.wr_addr    = pos_reg;
                        m.wr_data    = rx_byte;
                        pos_next     = pos_inc;
                        remain_next  = remain_dec;
                        r.bus_action = ACT_CONT;
                        r.ack_enable = (remain_dec != 7'd1);
                    end
                    ST_DATA_RX_NACK:
                    begin
                        m.wr_en       = 1'b1;
                        m.wr_addr     = pos_reg;
                        m.wr_data     = rx_byte;
                        remain_next   = remain_dec;
                        r.notice      = NT_RDONE;
                        r.notice_code = RDONE_CODE;
                        r.bus_action  = ACT_STOP;
                        phase_next    = PH_IDLE;
                    end
                    default:
                    begin
                        r.notice      = err_notice;
                        r.notice_code = (err_notice != NT_NONE) ? bus_status : 8'h00;
                        r.bus_action  = ACT_STOP;
                        phase_next    = PH_IDLE;
                    end
                endcase
            end
            MODE_READ:
            begin
                m.rd_addr       = POS_W'(buf_index);
                r.read_from_mem = 1'b1;
            end
            default:
            begin
            end
        endcase

        unique case (phase_next)
            PH_TX:   r.phase_now = PH_OUT_TX;
            PH_RX:   r.phase_now = PH_OUT_RX;
            default: r.phase_now = PH_OUT_IDLE;
        endcase

        if (!accept)
        begin
            m.wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            target_reg <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
        end
    end

    assign rec     = r;
    assign mem_req = m;

`ifndef ASSERT_OFF
    a_refused_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && r.refused |=> $stable(phase_reg) && $stable(remain_reg))
        else $error("refused start changed sequencer state");

    a_stop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (r.bus_action == ACT_STOP) |=> phase_reg == PH_IDLE)
        else $error("stop issued but phase not idle");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (r.bus_action == ACT_START) |=> phase_reg != PH_IDLE && pos_reg == '0)
        else $error("accepted start did not arm the sequencer");
`endif

endmodule

FILE: sv/ibs_back.sv
module ibs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ibs_pkg::stage_t   rec,
    input  logic [7:0]        rd_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output ibs_pkg::result_t  res
);
    import ibs_pkg::*;

    stage_t            stage_reg;
    logic              stage_v_reg;
    result_t           merged;
    result_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop_q;
    logic [QCNT_W:0]   occupancy;

    // store read data is registered at the accepting edge, together with the staged record
    always_comb
    begin
        merged.bus_action  = stage_reg.bus_action;
        merged.ack_enable  = stage_reg.ack_enable;
        merged.drive_byte  = stage_reg.drive_from_mem ? rd_data : stage_reg.drive_byte;
        merged.drive_valid = stage_reg.drive_valid;
        merged.notice      = stage_reg.notice;
        merged.notice_code = stage_reg.notice_code;
        merged.refused     = stage_reg.refused;
        merged.read_value  = stage_reg.read_from_mem ? rd_data : 8'h00;
        merged.phase_now   = stage_reg.phase_now;
    end

    assign pop_q     = pop && (count_reg != '0);
    assign occupancy = {1'b0, count_reg} + (QCNT_W + 1)'(stage_v_reg);
    // the stage slot counts against the queue, so a staged result always fits
    assign full      = occupancy >= (QCNT_W + 1)'(QDEPTH);
    assign empty     = (count_reg == '0);
    assign res       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (stage_v_reg && !pop_q)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!stage_v_reg && pop_q)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= rec;
        end
        if (stage_v_reg)
        begin
            q_reg[wr_ptr_reg] <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            stage_v_reg <= accept;
            count_reg   <= count_next;
            if (stage_v_reg)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop_q)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stage_v_reg && !pop_q |-> count_reg < QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_accept_stages: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stage_v_reg)
        else $error("accepted transaction not staged");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        stage_v_reg && !pop_q |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count lost a staged result");
`endif

endmodule

FILE: sv/i2c_master_byte_sequencer.sv
// I2C master byte sequencer. Each transaction on the input queue is one of: load a byte into
// the byte store, start a write or read (address + length; refused while a transfer is in
// progress), a bus status event, or a read-back of a store byte. Every transaction yields
// exactly one result on the output queue, in order: bus action, ack enable, byte to drive,
// completion/error notice, refused flag, read-back byte and the phase after the step.
// A transaction is taken every cycle while full is low. The store read and the staged record
// register at the accepting edge; the queue entry is then written from them, and the result
// shows on the output ports once it is in the queue, from where it can be popped.
// full counts the staged result against the 4-entry result queue, so a stalled consumer
// backs up the input once four results are held in the block. Store entries never
// loaded read back undefined; positions at or above BUF_DEPTH drop writes and read zero.
module i2c_master_byte_sequencer #(
    parameter int BUF_DEPTH = ibs_pkg::BUF_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // input queue
    input  logic       push,
    output logic       full,
    input  logic [2:0] mode,
    input  logic [7:0] dev_addr,
    input  logic [6:0] xfer_len,
    input  logic [7:0] bus_status,
    input  logic [7:0] rx_byte,
    input  logic [5:0] buf_index,
    input  logic [7:0] buf_value,
    // result queue
    output logic       empty,
    input  logic       pop,
    output logic [1:0] bus_action,
    output logic       ack_enable,
    output logic [7:0] drive_byte,
    output logic       drive_valid,
    output logic [2:0] notice,
    output logic [7:0] notice_code,
    output logic       refused,
    output logic [7:0] read_value,
    output logic [1:0] phase_now
);
    import ibs_pkg::*;

    logic     accept;
    stage_t   rec;
    mem_req_t mem_req;
    logic [7:0] rd_data;
    result_t  res;

    assign accept = push && !full;

    // front: decode the transaction, advance the transfer state, issue store access
    ibs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .dev_addr   (dev_addr),
        .xfer_len   (xfer_len),
        .bus_status (bus_status),
        .rx_byte    (rx_byte),
        .buf_index  (buf_index),
        .buf_value  (buf_value),
        .rec        (rec),
        .mem_req    (mem_req)
    );

    // byte store with registered read
    ibs_store #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // back: merge store data into the staged result and queue it for the consumer
    ibs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rec     (rec),
        .rd_data (rd_data),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .res     (res)
    );

    assign bus_action  = res.bus_action;
    assign ack_enable  = res.ack_enable;
    assign drive_byte  = res.drive_byte;
    assign drive_valid = res.drive_valid;
    assign notice      = res.notice;
    assign notice_code = res.notice_code;
    assign refused     = res.refused;
    assign read_value  = res.read_value;
    assign phase_now   = res.phase_now;

endmodule
